[sv/rfns_pkg.sv]
// rfns_pkg: shared types, widths, register codes and pixel helpers for the
// frame store nearest-neighbor scaler. No dependencies.
package rfns_pkg;

  // Field and internal widths fixed by the item format
  localparam int SRC_DIM_W   = 11;  // source width/height/stride registers
  localparam int OUT_DIM_W   = 13;  // output width/height registers
  localparam int COORD_W     = 12;  // output coordinate fields
  localparam int POS_W       = 10;  // source column/row position
  localparam int PIX_W       = 16;  // RGB565 pixel
  localparam int CH_W        = 8;   // expanded color channel
  localparam int PROD_W      = 22;  // coordinate times source dimension
  localparam int ADDR_FULL_W = 20;  // row*width + column, unclipped
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [SRC_DIM_W-1:0] SRC_MAX = 11'd1024;
  localparam logic [OUT_DIM_W-1:0] OUT_MAX = 13'd4096;
  localparam logic [CH_W-1:0]      ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd4;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Read sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_ADDR,
    ST_OUT
  } state_t;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Zero reads as one, large values saturate
  function automatic logic [SRC_DIM_W-1:0] clamp_src(input logic [SRC_DIM_W-1:0] v);
    logic [SRC_DIM_W-1:0] r;
    if (v == '0) r = SRC_DIM_W'(1);
    else if (v > SRC_MAX) r = SRC_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [OUT_DIM_W-1:0] clamp_out(input logic [OUT_DIM_W-1:0] v);
    logic [OUT_DIM_W-1:0] r;
    if (v == '0) r = OUT_DIM_W'(1);
    else if (v > OUT_MAX) r = OUT_MAX;
    else r = v;
    return r;
  endfunction

  // Bit replication to 8 bits
  function automatic logic [CH_W-1:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [CH_W-1:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

[sv/rfns_ifs.sv]
// rfns_ifs: valid/ready channel interfaces for items, results and config.
// Depends on rfns_pkg.
interface rfns_in_if;
  import rfns_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [PIX_W-1:0]   source_pixel;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  modport source (output valid, opcode, source_pixel, out_x, out_y, input ready);
  modport sink   (input valid, opcode, source_pixel, out_x, out_y, output ready);
endinterface

interface rfns_out_if;
  import rfns_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] alpha;
  logic            ok;
  modport source (output valid, blue, green, red, alpha, ok, input ready);
  modport sink   (input valid, blue, green, red, alpha, ok, output ready);
endinterface

interface rfns_cfg_if;
  import rfns_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/rfns_ram.sv]
// rfns_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/rfns_div.sv]
// rfns_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on rfns_pkg for the control/status structs.
module rfns_div #(
  parameter int DW = 22,  // dividend and quotient width
  parameter int VW = 13   // divisor width
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rfns_pkg::div_ctrl_t       ctrl,
  input  logic [DW-1:0]             dividend,
  input  logic [VW-1:0]             divisor,
  output rfns_pkg::div_stat_t       stat,
  output logic [DW-1:0]             quotient
);
  import rfns_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;

  // One restoring step
  always_comb begin
    shifted  = {rem_r, q_r[DW-1]};
    diff     = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[VW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

[sv/rgb565_frame_nearest_scaler.sv]
// rgb565_frame_nearest_scaler: RGB565 frame store with a nearest-neighbor
// scaled read port returning 8-bit BGRA. Write items: one per cycle, back
// to back, while no read is in flight. Read items pass through two 22-step
// serial dividers (column and row map) plus multiply, address and RAM read
// stages; one read is in flight at a time. Reset (rst_n, sync, active low)
// restores register defaults and clears frame position/ready.
// Depends on rfns_pkg, rfns_ifs, rfns_ram, rfns_div.
module rgb565_frame_nearest_scaler #(
  parameter int FRAME_DEPTH = 131072
) (
  input  logic        clk,
  input  logic        rst_n,
  rfns_in_if.sink     in_ch,
  rfns_out_if.source  out_ch,
  rfns_cfg_if.sink    cfg_ch
);
  import rfns_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam logic [ADDR_FULL_W:0] DEPTH_CMP = (ADDR_FULL_W + 1)'(FRAME_DEPTH);

  // Configuration, stored already clamped
  logic [SRC_DIM_W-1:0] sw_r, sw_nxt, sh_r, sh_nxt, st_r, st_nxt;
  logic [OUT_DIM_W-1:0] ow_r, ow_nxt, oh_r, oh_nxt;

  // Frame write position
  logic [POS_W-1:0]       wcol_r, wcol_nxt, wrow_r, wrow_nxt;
  logic [ADDR_FULL_W-1:0] row_base_r, row_base_nxt;
  logic                   ready_r, ready_nxt;

  // Read sequencer
  state_t                 state_r, state_nxt;
  logic [COORD_W-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic [ADDR_FULL_W-1:0] row_idx_r, row_idx_nxt;
  logic                   addr_ok_r, addr_ok_nxt;

  // Result register
  logic                   oval_r, oval_nxt;
  logic [CH_W-1:0]        blue_r, blue_nxt, green_r, green_nxt, red_r, red_nxt;
  logic                   ok_r, ok_nxt;

  // Handshake and datapath nets
  logic                   in_xfer, cfg_xfer, out_xfer;
  logic                   ignored;
  logic [ADDR_FULL_W-1:0] waddr_full, raddr_full;
  logic                   ram_we, ram_re;
  logic [PIX_W-1:0]       ram_rdata;
  logic [PROD_W-1:0]      prod_x, prod_y;
  logic [PROD_W-1:0]      qx, qy;
  div_ctrl_t              div_ctrl;
  div_stat_t              stat_x, stat_y;
  logic [SRC_DIM_W:0]     col_inc, row_inc;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;
  assign out_xfer = oval_r && out_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Write address and stride checks
  assign ignored    = (st_r < sw_r);
  assign waddr_full = row_base_r + ADDR_FULL_W'(wcol_r);
  assign col_inc    = {1'b0, SRC_DIM_W'(wcol_r)} + (SRC_DIM_W + 1)'(1);
  assign row_inc    = {1'b0, SRC_DIM_W'(wrow_r)} + (SRC_DIM_W + 1)'(1);
  assign ram_we     = in_xfer && (in_ch.opcode == OP_WRITE) && !ignored &&
                      ({1'b0, SRC_DIM_W'(wcol_r)} < {1'b0, sw_r}) &&
                      ({1'b0, waddr_full} < DEPTH_CMP);

  // Coordinate products feeding the dividers
  assign prod_x = PROD_W'(x_r) * PROD_W'(sw_r);
  assign prod_y = PROD_W'(y_r) * PROD_W'(sh_r);

  // Read address: mapped row base plus mapped column
  assign raddr_full = row_idx_r + ADDR_FULL_W'(qx[POS_W-1:0]);

  // Configuration and frame write position
  always_comb begin
    sw_nxt       = sw_r;
    sh_nxt       = sh_r;
    st_nxt       = st_r;
    ow_nxt       = ow_r;
    oh_nxt       = oh_r;
    wcol_nxt     = wcol_r;
    wrow_nxt     = wrow_r;
    row_base_nxt = row_base_r;
    ready_nxt    = ready_r;
    if (cfg_xfer) begin
      case (cfg_ch.index)
        CFG_SRC_WIDTH:  sw_nxt = clamp_src(cfg_ch.data[SRC_DIM_W-1:0]);
        CFG_SRC_HEIGHT: sh_nxt = clamp_src(cfg_ch.data[SRC_DIM_W-1:0]);
        CFG_SRC_STRIDE: st_nxt = clamp_src(cfg_ch.data[SRC_DIM_W-1:0]);
        CFG_OUT_WIDTH:  ow_nxt = clamp_out(cfg_ch.data);
        CFG_OUT_HEIGHT: oh_nxt = clamp_out(cfg_ch.data);
        default: ;
      endcase
      // Any source register restarts the frame
      if (cfg_ch.index inside {CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_SRC_STRIDE}) begin
        wcol_nxt     = '0;
        wrow_nxt     = '0;
        row_base_nxt = '0;
        ready_nxt    = 1'b0;
      end
    end else if (in_xfer && (in_ch.opcode == OP_WRITE)) begin
      if (col_inc >= {1'b0, st_r}) begin
        wcol_nxt = '0;
        if (row_inc >= {1'b0, sh_r}) begin
          wrow_nxt     = '0;
          row_base_nxt = '0;
          if (!ignored) ready_nxt = 1'b1;
        end else begin
          wrow_nxt     = row_inc[POS_W-1:0];
          row_base_nxt = row_base_r + ADDR_FULL_W'(sw_r);
        end
      end else begin
        wcol_nxt = col_inc[POS_W-1:0];
      end
    end
  end

  // Read sequencer: next state and outputs
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    rd_ok_nxt      = rd_ok_r;
    row_idx_nxt    = row_idx_r;
    addr_ok_nxt    = addr_ok_r;
    div_ctrl.start = 1'b0;
    ram_re         = 1'b0;
    oval_nxt       = out_xfer ? 1'b0 : oval_r;
    blue_nxt       = blue_r;
    green_nxt      = green_r;
    red_nxt        = red_r;
    ok_nxt         = ok_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_ch.opcode == OP_READ)) begin
          x_nxt     = in_ch.out_x;
          y_nxt     = in_ch.out_y;
          rd_ok_nxt = ready_r && ({1'b0, in_ch.out_x} < ow_r) &&
                      ({1'b0, in_ch.out_y} < oh_r);
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        div_ctrl.start = 1'b1;
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        if (stat_x.done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        row_idx_nxt = ADDR_FULL_W'(qy[POS_W-1:0]) * ADDR_FULL_W'(sw_r);
        state_nxt   = ST_ADDR;
      end
      ST_ADDR: begin
        ram_re      = 1'b1;
        addr_ok_nxt = rd_ok_r && ({1'b0, raddr_full} < DEPTH_CMP);
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // Load the result once the output register is free
        if (!oval_r || out_ch.ready) begin
          oval_nxt  = 1'b1;
          ok_nxt    = addr_ok_r;
          blue_nxt  = addr_ok_r ? expand5(ram_rdata[4:0])   : '0;
          green_nxt = addr_ok_r ? expand6(ram_rdata[10:5])  : '0;
          red_nxt   = addr_ok_r ? expand5(ram_rdata[15:11]) : '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r       <= 11'd320;
      sh_r       <= 11'd240;
      st_r       <= 11'd320;
      ow_r       <= 13'd320;
      oh_r       <= 13'd240;
      wcol_r     <= '0;
      wrow_r     <= '0;
      row_base_r <= '0;
      ready_r    <= 1'b0;
      state_r    <= ST_IDLE;
      oval_r     <= 1'b0;
    end else begin
      sw_r       <= sw_nxt;
      sh_r       <= sh_nxt;
      st_r       <= st_nxt;
      ow_r       <= ow_nxt;
      oh_r       <= oh_nxt;
      wcol_r     <= wcol_nxt;
      wrow_r     <= wrow_nxt;
      row_base_r <= row_base_nxt;
      ready_r    <= ready_nxt;
      state_r    <= state_nxt;
      oval_r     <= oval_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    rd_ok_r   <= rd_ok_nxt;
    row_idx_r <= row_idx_nxt;
    addr_ok_r <= addr_ok_nxt;
    blue_r    <= blue_nxt;
    green_r   <= green_nxt;
    red_r     <= red_nxt;
    ok_r      <= ok_nxt;
  end

  // Column and row mapping dividers
  rfns_div #(.DW(PROD_W), .VW(OUT_DIM_W)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (prod_x),
    .divisor  (ow_r),
    .stat     (stat_x),
    .quotient (qx)
  );

  rfns_div #(.DW(PROD_W), .VW(OUT_DIM_W)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (prod_y),
    .divisor  (oh_r),
    .stat     (stat_y),
    .quotient (qy)
  );

  // Frame store
  rfns_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_full[AW-1:0]),
    .wdata (in_ch.source_pixel),
    .re    (ram_re),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Result port
  assign out_ch.valid = oval_r;
  assign out_ch.blue  = blue_r;
  assign out_ch.green = green_r;
  assign out_ch.red   = red_r;
  assign out_ch.alpha = ALPHA_OPAQUE;
  assign out_ch.ok    = ok_r;

  // Both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (stat_x.done == stat_y.done) && (stat_x.busy == stat_y.busy))
    else $error("column and row dividers out of step");

  // The store is written only while no read is in flight
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("frame store written during a read");

  // A rejected read carries black
  a_bad_black: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && !ok_r) |-> (blue_r == '0 && green_r == '0 && red_r == '0))
    else $error("invalid read returned color");

  // Write column never reaches the stride
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, SRC_DIM_W'(wcol_r)} < {1'b0, st_r}))
    else $error("write column beyond stride");

endmodule
